### design/bankers_safety_check_defines.svh
// ---------------------------------------------------------------------------
// bankers_safety_check_defines.svh
// Assertion macros for the safety check block. They compile to nothing
// when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BANKERS_SAFETY_CHECK_DEFINES_SVH
`define BANKERS_SAFETY_CHECK_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bankers_safety_check: implication check failed");
// next-cycle implication
`define BSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bankers_safety_check: next-cycle check failed");
`else
`define BSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/bsc_pkg.sv
// ---------------------------------------------------------------------------
// bsc_pkg
// Shared constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package bsc_pkg;

    // parameter defaults
    localparam int MAX_PROCESSES_DEF = 16;
    localparam int MAX_RESOURCES_DEF = 8;
    localparam int COUNT_BITS_DEF    = 16;

    // fixed field widths
    localparam int FUNC_W     = 2;
    localparam int PROC_IDX_W = 4;
    localparam int RES_IDX_W  = 3;
    localparam int SEQ_W      = 4;

    // configuration port
    localparam int PROC_REG_W = 5;
    localparam int RES_REG_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_COUNT = 2'd1;

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_AVAIL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RUN        = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic ld_alloc;     // write alloc/need entry from input item
        logic ld_avail;     // write available count from input item
        logic run_start;    // clear finished flags and grant count
        logic clr_fail;     // clear need check fail flag
        logic rd_en;        // read alloc/need tables at rd_addr
        logic rd_add;       // this read feeds the available update
        logic out_grant;    // load a grant record for the current process
        logic out_verdict;  // load the final verdict
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;     // output register can take an item this cycle
        logic chk_pass;     // every need checked so far fits
        logic finished;     // current process already granted
    } t_dp_stat;

endpackage

### design/bsc_datapath.sv
// ---------------------------------------------------------------------------
// bsc_datapath
// Allocation and need tables, available counts, finished flags, grant
// counter and the result output register.
// ---------------------------------------------------------------------------
module bsc_datapath #(
    parameter int MAX_PROCESSES = bsc_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = bsc_pkg::MAX_RESOURCES_DEF,
    parameter int COUNT_BITS    = bsc_pkg::COUNT_BITS_DEF,
    localparam int P_W   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
    localparam int NP_W  = $clog2(MAX_PROCESSES + 1),
    localparam int R_W   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1,
    localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES,
    localparam int A_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bsc_pkg::t_dp_cmd                i_cmd,
    output bsc_pkg::t_dp_stat               o_stat,
    input  logic [P_W-1:0]                  i_cur_p,
    input  logic [NP_W-1:0]                 i_np,
    input  logic [A_W-1:0]                  i_rd_addr,
    input  logic [R_W-1:0]                  i_rd_j,
    input  logic [bsc_pkg::PROC_IDX_W-1:0]  i_proc_index,
    input  logic [bsc_pkg::RES_IDX_W-1:0]   i_res_index,
    input  logic [COUNT_BITS-1:0]           i_alloc_value,
    input  logic [COUNT_BITS-1:0]           i_max_value,
    input  logic [COUNT_BITS-1:0]           i_avail_value,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic                            o_is_verdict,
    output logic [bsc_pkg::PROC_IDX_W-1:0]  o_granted_process,
    output logic [bsc_pkg::SEQ_W-1:0]       o_seq_position,
    output logic                            o_safe,
    output logic                            o_last
);

    localparam int AV_W = COUNT_BITS + 8;
    localparam int ND_W = COUNT_BITS + 1;

    logic [COUNT_BITS-1:0] r_alloc_mem [DEPTH];
    logic [ND_W-1:0]       r_need_mem  [DEPTH];
    logic [COUNT_BITS-1:0] r_alloc_q;
    logic [ND_W-1:0]       r_need_q;
    logic                  r_rd_vld;
    logic                  r_rd_add;
    logic [R_W-1:0]        r_rd_j;
    logic [AV_W-1:0]       r_avail [MAX_RESOURCES];
    logic                  r_fail;
    logic [MAX_PROCESSES-1:0] r_fin;
    logic [NP_W-1:0]       r_grant_cnt;
    logic                  r_out_vld;
    logic                  r_out_verdict;
    logic [bsc_pkg::PROC_IDX_W-1:0] r_out_proc;
    logic [bsc_pkg::SEQ_W-1:0]      r_out_pos;
    logic                  r_out_safe;
    logic                  r_out_last;

    logic            w_ld_ok;
    logic            w_av_ok;
    logic [A_W-1:0]  w_wr_addr;
    logic [ND_W-1:0] w_need;
    logic [AV_W-1:0] w_avail_cur;
    logic [AV_W:0]   w_sum;
    logic [AV_W-1:0] w_sat;
    logic            w_cur_fail;
    logic            w_out_free;

    // load addressing; out-of-range rows or columns are dropped
    assign w_ld_ok   = (32'(i_proc_index) < MAX_PROCESSES) && (32'(i_res_index) < MAX_RESOURCES);
    assign w_av_ok   = 32'(i_res_index) < MAX_RESOURCES;
    assign w_wr_addr = A_W'(32'(i_proc_index) * MAX_RESOURCES + 32'(i_res_index));
    assign w_need    = {1'b0, i_max_value} - {1'b0, i_alloc_value};

    // allocation table, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_alloc && w_ld_ok) begin
            r_alloc_mem[w_wr_addr] <= i_alloc_value;
        end
        if (i_cmd.rd_en) begin
            r_alloc_q <= r_alloc_mem[i_rd_addr];
        end
    end

    // need table (signed, max minus alloc), registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_alloc && w_ld_ok) begin
            r_need_mem[w_wr_addr] <= w_need;
        end
        if (i_cmd.rd_en) begin
            r_need_q <= r_need_mem[i_rd_addr];
        end
    end

    // read pipeline tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_add <= i_cmd.rd_add;
            r_rd_j   <= i_rd_j;
        end
    end

    // compare and saturating add against the column just read
    assign w_avail_cur = r_avail[r_rd_j];
    assign w_cur_fail  = !r_need_q[ND_W-1] && (AV_W'(r_need_q) > w_avail_cur);
    assign w_sum       = {1'b0, w_avail_cur} + (AV_W + 1)'(r_alloc_q);
    assign w_sat       = w_sum[AV_W] ? {AV_W{1'b1}} : w_sum[AV_W-1:0];

    // available counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_RESOURCES; k++) begin
                r_avail[k] <= '0;
            end
        end else begin
            if (i_cmd.ld_avail && w_av_ok) begin
                r_avail[R_W'(i_res_index)] <= AV_W'(i_avail_value);
            end
            if (r_rd_vld && r_rd_add) begin
                r_avail[r_rd_j] <= w_sat;
            end
        end
    end

    // sticky fail flag over one process check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail <= 1'b0;
        end else if (i_cmd.clr_fail) begin
            r_fail <= 1'b0;
        end else if (r_rd_vld && !r_rd_add && w_cur_fail) begin
            r_fail <= 1'b1;
        end
    end

    // finished flags and grant count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin       <= '0;
            r_grant_cnt <= '0;
        end else if (i_cmd.run_start) begin
            r_fin       <= '0;
            r_grant_cnt <= '0;
        end else if (i_cmd.out_grant) begin
            r_fin[i_cur_p] <= 1'b1;
            r_grant_cnt    <= r_grant_cnt + 1'b1;
        end
    end

    // output register
    assign w_out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_grant || i_cmd.out_verdict) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_grant) begin
            r_out_verdict <= 1'b0;
            r_out_proc    <= bsc_pkg::PROC_IDX_W'(i_cur_p);
            r_out_pos     <= bsc_pkg::SEQ_W'(r_grant_cnt);
            r_out_safe    <= 1'b0;
            r_out_last    <= 1'b0;
        end else if (i_cmd.out_verdict) begin
            r_out_verdict <= 1'b1;
            r_out_proc    <= '0;
            r_out_pos     <= '0;
            r_out_safe    <= (r_grant_cnt == i_np);
            r_out_last    <= 1'b1;
        end
    end

    // status back to the controller
    assign o_stat.out_free = w_out_free;
    assign o_stat.chk_pass = !r_fail && !(r_rd_vld && !r_rd_add && w_cur_fail);
    assign o_stat.finished = r_fin[i_cur_p];

    assign o_out_valid       = r_out_vld;
    assign o_is_verdict      = r_out_verdict;
    assign o_granted_process = r_out_proc;
    assign o_seq_position    = r_out_pos;
    assign o_safe            = r_out_safe;
    assign o_last            = r_out_last;

endmodule

### design/bsc_ctrl.sv
// ---------------------------------------------------------------------------
// bsc_ctrl
// Configuration registers and the sequencer that walks passes, processes
// and resource columns of a run.
// ---------------------------------------------------------------------------
`include "bankers_safety_check_defines.svh"

module bsc_ctrl #(
    parameter int MAX_PROCESSES = bsc_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = bsc_pkg::MAX_RESOURCES_DEF,
    localparam int P_W   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
    localparam int NP_W  = $clog2(MAX_PROCESSES + 1),
    localparam int R_W   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1,
    localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES,
    localparam int A_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bsc_pkg::FUNC_W-1:0]      i_func,
    output bsc_pkg::t_dp_cmd                o_cmd,
    input  bsc_pkg::t_dp_stat               i_stat,
    output logic [P_W-1:0]                  o_cur_p,
    output logic [NP_W-1:0]                 o_np,
    output logic [A_W-1:0]                  o_rd_addr,
    output logic [R_W-1:0]                  o_rd_j
);

    localparam int NR_W = $clog2(MAX_RESOURCES + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_PROC    = 3'd1;
    localparam logic [2:0] S_CHK     = 3'd2;
    localparam logic [2:0] S_CHK_END = 3'd3;
    localparam logic [2:0] S_GRANT   = 3'd4;
    localparam logic [2:0] S_ADD     = 3'd5;
    localparam logic [2:0] S_ADD_END = 3'd6;
    localparam logic [2:0] S_VERD    = 3'd7;

    logic [2:0]                       r_state, n_state;
    logic [P_W-1:0]                   r_p, n_p;
    logic [P_W-1:0]                   r_pass, n_pass;
    logic [R_W-1:0]                   r_j, n_j;
    logic [bsc_pkg::PROC_REG_W-1:0]   r_procs;
    logic [bsc_pkg::RES_REG_W-1:0]    r_res;

    logic [NP_W-1:0] w_np;
    logic [NR_W-1:0] w_nr;
    logic            w_accept;
    logic            w_last_p;
    logic            w_last_pass;
    logic            w_last_j;
    logic            v_adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_procs <= bsc_pkg::PROC_REG_W'(1);
            r_res   <= bsc_pkg::RES_REG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bsc_pkg::CFG_PROCESS_COUNT: begin
                    r_procs <= i_cfg_wdata[bsc_pkg::PROC_REG_W-1:0];
                end
                bsc_pkg::CFG_RESOURCE_COUNT: begin
                    r_res <= i_cfg_wdata[bsc_pkg::RES_REG_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // counts in use, clamped to the table size
    always_comb begin
        if (32'(r_procs) > MAX_PROCESSES) begin
            w_np = NP_W'(MAX_PROCESSES);
        end else begin
            w_np = NP_W'(r_procs);
        end
        if (32'(r_res) > MAX_RESOURCES) begin
            w_nr = NR_W'(MAX_RESOURCES);
        end else begin
            w_nr = NR_W'(r_res);
        end
    end

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_last_p    = (NP_W'(r_p) == w_np - NP_W'(1));
    assign w_last_pass = (NP_W'(r_pass) == w_np - NP_W'(1));
    assign w_last_j    = (NR_W'(r_j) == w_nr - NR_W'(1));

    // sequencer
    always_comb begin
        n_state = r_state;
        n_p     = r_p;
        n_pass  = r_pass;
        n_j     = r_j;
        o_cmd   = '0;
        v_adv   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_func)
                        bsc_pkg::FUNC_LOAD_ALLOC: o_cmd.ld_alloc = 1'b1;
                        bsc_pkg::FUNC_LOAD_AVAIL: o_cmd.ld_avail = 1'b1;
                        bsc_pkg::FUNC_RUN: begin
                            o_cmd.run_start = 1'b1;
                            n_p     = '0;
                            n_pass  = '0;
                            n_state = (w_np == '0) ? S_VERD : S_PROC;
                        end
                        default: ;
                    endcase
                end
            end
            S_PROC: begin
                o_cmd.clr_fail = 1'b1;
                n_j = '0;
                if (i_stat.finished) begin
                    v_adv = 1'b1;
                end else if (w_nr == '0) begin
                    n_state = S_GRANT;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.rd_en = 1'b1;
                if (w_last_j) begin
                    n_state = S_CHK_END;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_CHK_END: begin
                if (i_stat.chk_pass) begin
                    n_state = S_GRANT;
                end else begin
                    v_adv = 1'b1;
                end
            end
            S_GRANT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_grant = 1'b1;
                    if (w_nr == '0) begin
                        v_adv = 1'b1;
                    end else begin
                        n_j     = '0;
                        n_state = S_ADD;
                    end
                end
            end
            S_ADD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_add = 1'b1;
                if (w_last_j) begin
                    n_state = S_ADD_END;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_ADD_END: begin
                // last column write lands at this edge
                v_adv = 1'b1;
            end
            S_VERD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_verdict = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // step to the next process, wrapping into the next pass
        if (v_adv) begin
            if (w_last_p) begin
                if (w_last_pass) begin
                    n_state = S_VERD;
                end else begin
                    n_pass  = r_pass + 1'b1;
                    n_p     = '0;
                    n_state = S_PROC;
                end
            end else begin
                n_p     = r_p + 1'b1;
                n_state = S_PROC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_p     <= '0;
            r_pass  <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_p     <= n_p;
            r_pass  <= n_pass;
            r_j     <= n_j;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cur_p    = r_p;
    assign o_np       = w_np;
    assign o_rd_j     = r_j;
    assign o_rd_addr  = A_W'(32'(r_p) * MAX_RESOURCES + 32'(r_j));

    // a process under check has not been granted yet
    `BSC_ASSERT_IMP(a_chk_unfinished, i_clk, i_rst_n, r_state == S_CHK, !i_stat.finished)
    // table reads stay inside the columns in use and inside the table
    `BSC_ASSERT_IMP(a_rd_in_range, i_clk, i_rst_n, o_cmd.rd_en,
                    (32'(r_j) < 32'(w_nr)) && (32'(o_rd_addr) < DEPTH))
    // a grant is emitted only from the grant step of an unfinished process
    `BSC_ASSERT_IMP(a_grant_src, i_clk, i_rst_n, o_cmd.out_grant,
                    (r_state == S_GRANT) && !i_stat.finished)
    // an accepted run always leaves idle
    `BSC_ASSERT_NEXT(a_run_busy, i_clk, i_rst_n, w_accept && (i_func == bsc_pkg::FUNC_RUN),
                     r_state != S_IDLE)

endmodule

### design/bankers_safety_check.sv
// ---------------------------------------------------------------------------
// bankers_safety_check
// Banker's algorithm safety check: table loader plus run sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   Write process_count (index 0) and resource_count (index 1) on the
//   configuration port while idle. Input items use i_in_valid/o_in_stall,
//   result items o_out_valid/i_out_stall.
//   func 0 writes one alloc/max entry, func 1 one available count; each
//   gives no result. func 3 is ignored.
//   func 2 runs the check: P passes over P processes (P, R = counts in use).
//   A finished process is skipped on each visit; an unfinished one has its
//   need compared column by column through the registered table read, and a
//   grant adds its allocation to the available counts the same way (one column
//   per cycle, single table read port).
//   Grant items stream out in order, then one verdict item with last set.
//   o_in_stall stays high for the whole run. The next item is taken while
//   the verdict still waits in the output register.
//   A stalled receiver holds the sequencer at its next grant or verdict.
//   Reset clears the available counts, flags and registers (counts to 1);
//   the alloc/need tables hold garbage until loaded. Reload available
//   counts before each run.
// ---------------------------------------------------------------------------
module bankers_safety_check #(
    parameter int MAX_PROCESSES = bsc_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = bsc_pkg::MAX_RESOURCES_DEF,
    parameter int COUNT_BITS    = bsc_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bsc_pkg::FUNC_W-1:0]      i_func,
    input  logic [bsc_pkg::PROC_IDX_W-1:0]  i_proc_index,
    input  logic [bsc_pkg::RES_IDX_W-1:0]   i_res_index,
    input  logic [COUNT_BITS-1:0]           i_alloc_value,
    input  logic [COUNT_BITS-1:0]           i_max_value,
    input  logic [COUNT_BITS-1:0]           i_avail_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_is_verdict,
    output logic [bsc_pkg::PROC_IDX_W-1:0]  o_granted_process,
    output logic [bsc_pkg::SEQ_W-1:0]       o_seq_position,
    output logic                            o_safe,
    output logic                            o_last
);

    localparam int P_W   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int NP_W  = $clog2(MAX_PROCESSES + 1);
    localparam int R_W   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
    localparam int A_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bsc_pkg::t_dp_cmd  w_cmd;
    bsc_pkg::t_dp_stat w_stat;
    logic [P_W-1:0]    w_cur_p;
    logic [NP_W-1:0]   w_np;
    logic [A_W-1:0]    w_rd_addr;
    logic [R_W-1:0]    w_rd_j;

    // sequencer and configuration
    bsc_ctrl #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat),
        .o_cur_p     (w_cur_p),
        .o_np        (w_np),
        .o_rd_addr   (w_rd_addr),
        .o_rd_j      (w_rd_j)
    );

    // tables, counters and output register
    bsc_datapath #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_cur_p           (w_cur_p),
        .i_np              (w_np),
        .i_rd_addr         (w_rd_addr),
        .i_rd_j            (w_rd_j),
        .i_proc_index      (i_proc_index),
        .i_res_index       (i_res_index),
        .i_alloc_value     (i_alloc_value),
        .i_max_value       (i_max_value),
        .i_avail_value     (i_avail_value),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_is_verdict      (o_is_verdict),
        .o_granted_process (o_granted_process),
        .o_seq_position    (o_seq_position),
        .o_safe            (o_safe),
        .o_last            (o_last)
    );

endmodule
